// ===== hdl/ipmd_pkg.sv =====
package ipmd_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int PWM_LIMIT   = 16800;
    localparam int FRAC_BITS   = 12;
    localparam int GAIN_FRAC   = 8;

    localparam int CH_W    = 2;
    localparam int SPEED_W = 16;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int GAIN_W  = 24;
    localparam int VOLT_W  = 16;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int INC_W   = PROD_W - GAIN_FRAC;
    localparam int ACC_W   = 28;
    localparam int SUM_W   = INC_W + 1;
    localparam int MAG_W   = 15;

    localparam logic signed [SUM_W-1:0] ACC_LIMIT = SUM_W'(PWM_LIMIT * (2 ** FRAC_BITS));

    localparam logic [VOLT_W-1:0] LV_THRESHOLD_RESET = VOLT_W'(20);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_GAIN_P    = 2'd0;
    localparam logic [1:0] REG_GAIN_I    = 2'd1;
    localparam logic [1:0] REG_LV_THRESH = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0]           channel;
        logic signed [SPEED_W-1:0] measured_speed;
        logic signed [SPEED_W-1:0] target_speed;
        logic [VOLT_W-1:0]         battery_voltage;
        logic                      enable_switch;
        logic                      stop_request;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [MAG_W-1:0] pwm_magnitude;
        logic             pin_one;
        logic             pin_two;
        logic             drive_blocked;
    } result_t;

endpackage

// ===== hdl/incremental_pi_motor_drive.sv =====
// Four-channel incremental PI wheel speed regulator with sign-magnitude bridge
// drive. Each item on the item channel is one control tick for one wheel; the
// block answers with exactly one result beat carrying the PWM compare magnitude,
// the two direction pin levels and a blocked flag. An item is registered on
// entry, then combinational logic (two gain multiplies in parallel, the
// accumulator add and the saturation) produces the result register and updates
// that wheel's error and accumulator state unless the tick is blocked, so one
// item is taken every cycle while the result side is not stalled. The item
// waits in the item register until the result register is free, then its
// result beat is registered there. Consecutive ticks for the same wheel are
// handled back to back. The user must write gains and the low-battery threshold
// over the APB port while no item is in flight; the block does not enforce it.
module incremental_pi_motor_drive (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ipmd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ipmd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ipmd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,

    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  ipmd_pkg::item_t                      item,

    output logic                                 result_valid,
    input  logic                                 result_ready,
    output ipmd_pkg::result_t                    result
);

    logic [ipmd_pkg::GAIN_W-1:0] gain_p_reg;
    logic [ipmd_pkg::GAIN_W-1:0] gain_i_reg;
    logic [ipmd_pkg::VOLT_W-1:0] lv_thresh_reg;

    logic                        item_valid_reg;
    ipmd_pkg::item_t             item_reg;
    logic                        result_valid_reg;
    ipmd_pkg::result_t           result_reg;
    ipmd_pkg::result_t           result_next;

    logic signed [ipmd_pkg::ERR_W-1:0] prev_err_reg [ipmd_pkg::MOTOR_COUNT];
    logic signed [ipmd_pkg::ACC_W-1:0] acc_reg      [ipmd_pkg::MOTOR_COUNT];

    logic                                advance;
    logic                                cfg_write;
    logic                                blocked;
    logic [ipmd_pkg::CH_W-1:0]           ch;
    logic signed [ipmd_pkg::ERR_W-1:0]   err;
    logic signed [ipmd_pkg::DIFF_W-1:0]  diff;
    logic signed [ipmd_pkg::GAIN_W:0]    kp_s;
    logic signed [ipmd_pkg::GAIN_W:0]    ki_s;
    logic signed [ipmd_pkg::PROD_W-1:0]  prod_p;
    logic signed [ipmd_pkg::PROD_W-1:0]  prod_i;
    logic signed [ipmd_pkg::PROD_W-1:0]  prod_sum;
    logic signed [ipmd_pkg::INC_W-1:0]   inc;
    logic signed [ipmd_pkg::SUM_W-1:0]   acc_sum;
    logic signed [ipmd_pkg::ACC_W-1:0]   acc_next;
    logic [ipmd_pkg::ACC_W-1:0]          acc_abs;
    logic [ipmd_pkg::MAG_W-1:0]          mag;
    logic                                positive;
    logic                                first_group;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            lv_thresh_reg <= ipmd_pkg::LV_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                ipmd_pkg::REG_GAIN_P:    gain_p_reg    <= pwdata[ipmd_pkg::GAIN_W-1:0];
                ipmd_pkg::REG_GAIN_I:    gain_i_reg    <= pwdata[ipmd_pkg::GAIN_W-1:0];
                ipmd_pkg::REG_LV_THRESH: lv_thresh_reg <= pwdata[ipmd_pkg::VOLT_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            ipmd_pkg::REG_GAIN_P:    prdata = ipmd_pkg::APB_DATA_W'(gain_p_reg);
            ipmd_pkg::REG_GAIN_I:    prdata = ipmd_pkg::APB_DATA_W'(gain_i_reg);
            ipmd_pkg::REG_LV_THRESH: prdata = ipmd_pkg::APB_DATA_W'(lv_thresh_reg);
            default:                 prdata = '0;
        endcase
    end

    // handshake
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // control law
    always_comb
    begin
        ch      = item_reg.channel;
        blocked = (item_reg.battery_voltage < lv_thresh_reg) || !item_reg.enable_switch
                  || item_reg.stop_request;

        err  = ipmd_pkg::ERR_W'(item_reg.target_speed)
               - ipmd_pkg::ERR_W'(item_reg.measured_speed);
        diff = ipmd_pkg::DIFF_W'(err) - ipmd_pkg::DIFF_W'(prev_err_reg[ch]);
        kp_s = signed'({1'b0, gain_p_reg});
        ki_s = signed'({1'b0, gain_i_reg});

        prod_p   = ipmd_pkg::PROD_W'(diff * kp_s);
        prod_i   = ipmd_pkg::PROD_W'(err * ki_s);
        prod_sum = prod_p + prod_i;
        inc      = prod_sum[ipmd_pkg::PROD_W-1:ipmd_pkg::GAIN_FRAC];

        acc_sum = ipmd_pkg::SUM_W'(acc_reg[ch]) + ipmd_pkg::SUM_W'(inc);
        if (acc_sum > ipmd_pkg::ACC_LIMIT)
        begin
            acc_next = ipmd_pkg::ACC_W'(ipmd_pkg::ACC_LIMIT);
        end
        else if (acc_sum < -ipmd_pkg::ACC_LIMIT)
        begin
            acc_next = ipmd_pkg::ACC_W'(-ipmd_pkg::ACC_LIMIT);
        end
        else
        begin
            acc_next = ipmd_pkg::ACC_W'(acc_sum);
        end

        // magnitude truncated toward zero
        acc_abs  = acc_next[ipmd_pkg::ACC_W-1] ? ipmd_pkg::ACC_W'(-acc_next)
                                                : ipmd_pkg::ACC_W'(acc_next);
        mag      = acc_abs[ipmd_pkg::FRAC_BITS +: ipmd_pkg::MAG_W];
        positive = !blocked && !acc_next[ipmd_pkg::ACC_W-1] && (mag != '0);

        first_group = (ch < ipmd_pkg::CH_W'(2));

        result_next.out_channel   = ch;
        result_next.pwm_magnitude = blocked ? '0 : mag;
        result_next.pin_one       = first_group ? !positive : positive;
        result_next.pin_two       = first_group ? positive : !positive;
        result_next.drive_blocked = blocked;
    end

    // per-wheel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ipmd_pkg::MOTOR_COUNT; i++)
            begin
                prev_err_reg[i] <= '0;
                acc_reg[i]      <= '0;
            end
        end
        else if (advance && !blocked)
        begin
            prev_err_reg[ch] <= err;
            acc_reg[ch]      <= acc_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/ipmd_checker.sv =====
module ipmd_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              result_valid,
    input  logic              result_ready,
    input  ipmd_pkg::result_t result
);

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.pwm_magnitude <= ipmd_pkg::MAG_W'(ipmd_pkg::PWM_LIMIT))
        else $error("pwm magnitude above limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.drive_blocked |-> result.pwm_magnitude == '0)
        else $error("blocked beat with nonzero drive");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.pin_one != result.pin_two)
        else $error("bridge pins not complementary");

endmodule

bind incremental_pi_motor_drive ipmd_checker u_ipmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ===== tb/incremental_pi_motor_drive_tb.sv =====
module incremental_pi_motor_drive_tb;

    localparam logic [1:0] REG_SPARE = 2'd3;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [ipmd_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [ipmd_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [ipmd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            item_valid = 1'b0;
    logic                            item_ready;
    ipmd_pkg::item_t                 item = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    ipmd_pkg::result_t               result;

    // register mirror and per-wheel regulator state
    logic [ipmd_pkg::GAIN_W-1:0]       kp_cfg;
    logic [ipmd_pkg::GAIN_W-1:0]       ki_cfg;
    logic [ipmd_pkg::VOLT_W-1:0]       lv_cfg;
    logic signed [ipmd_pkg::ERR_W-1:0] wheel_last_error [ipmd_pkg::MOTOR_COUNT];
    logic signed [ipmd_pkg::ACC_W-1:0] wheel_accum [ipmd_pkg::MOTOR_COUNT];

    ipmd_pkg::result_t expected_drive [$];
    int                fault_count = 0;
    bit                send_calm = 1'b0;
    bit                recv_calm = 1'b0;

    incremental_pi_motor_drive i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    function automatic ipmd_pkg::result_t predict_drive(input ipmd_pkg::item_t it);
        ipmd_pkg::result_t r;
        longint  err;
        longint  diff;
        longint  acc;
        longint  lim;
        longint  drive;
        longint  mag;
        bit      blocked;
        bit      forward;
        bit      pin_a;
        blocked = (it.battery_voltage < lv_cfg) || !it.enable_switch || it.stop_request;
        forward = 1'b0;
        r.out_channel = it.channel;
        r.pwm_magnitude = '0;
        r.drive_blocked = blocked;
        if (it.channel >= ipmd_pkg::MOTOR_COUNT)
        begin
            r.drive_blocked = 1'b0;
        end
        else if (!blocked)
        begin
            err = longint'($signed(it.target_speed)) - longint'($signed(it.measured_speed));
            diff = err - longint'(wheel_last_error[it.channel]);
            acc = (longint'(kp_cfg) * diff + longint'(ki_cfg) * err) >>> ipmd_pkg::GAIN_FRAC;
            acc = acc + longint'(wheel_accum[it.channel]);
            lim = longint'(ipmd_pkg::PWM_LIMIT) << ipmd_pkg::FRAC_BITS;
            if (acc > lim)
            begin
                acc = lim;
            end
            if (acc < -lim)
            begin
                acc = -lim;
            end
            wheel_accum[it.channel] = ipmd_pkg::ACC_W'(acc);
            wheel_last_error[it.channel] = ipmd_pkg::ERR_W'(err);
            drive = acc / (longint'(1) << ipmd_pkg::FRAC_BITS);
            mag = (drive < 0) ? -drive : drive;
            r.pwm_magnitude = ipmd_pkg::MAG_W'(mag);
            forward = drive > 0;
        end
        pin_a = (it.channel < 2) ? !forward : forward;
        r.pin_one = pin_a;
        r.pin_two = !pin_a;
        return r;
    endfunction

    function automatic logic [ipmd_pkg::APB_DATA_W-1:0] reg_mirror(input logic [1:0] index);
        case (index)
            ipmd_pkg::REG_GAIN_P:    return ipmd_pkg::APB_DATA_W'(kp_cfg);
            ipmd_pkg::REG_GAIN_I:    return ipmd_pkg::APB_DATA_W'(ki_cfg);
            ipmd_pkg::REG_LV_THRESH: return ipmd_pkg::APB_DATA_W'(lv_cfg);
            default:                 return '0;
        endcase
    endfunction

    function automatic ipmd_pkg::item_t make_tick(input logic [ipmd_pkg::CH_W-1:0] ch,
                                                  input int meas, input int targ,
                                                  input int volt,
                                                  input bit en, input bit stop);
        ipmd_pkg::item_t it;
        it.channel = ch;
        it.measured_speed = ipmd_pkg::SPEED_W'(meas);
        it.target_speed = ipmd_pkg::SPEED_W'(targ);
        it.battery_voltage = ipmd_pkg::VOLT_W'(volt);
        it.enable_switch = en;
        it.stop_request = stop;
        return it;
    endfunction

    function automatic ipmd_pkg::item_t random_tick();
        ipmd_pkg::item_t it;
        it.channel = ipmd_pkg::CH_W'($urandom_range(0, ipmd_pkg::MOTOR_COUNT - 1));
        if ($urandom_range(0, 3) == 0)
        begin
            it.measured_speed = ipmd_pkg::SPEED_W'($urandom);
            it.target_speed = ipmd_pkg::SPEED_W'($urandom);
        end
        else
        begin
            it.target_speed = ipmd_pkg::SPEED_W'($urandom_range(0, 16383))
                              - ipmd_pkg::SPEED_W'(8192);
            it.measured_speed = it.target_speed
                                + ipmd_pkg::SPEED_W'($urandom_range(0, 2047))
                                - ipmd_pkg::SPEED_W'(1024);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            it.battery_voltage = ipmd_pkg::VOLT_W'($urandom);
        end
        else
        begin
            it.battery_voltage = ipmd_pkg::VOLT_W'($urandom_range(int'(lv_cfg), 65535));
        end
        it.enable_switch = $urandom_range(0, 15) != 0;
        it.stop_request = $urandom_range(0, 15) == 0;
        return it;
    endfunction

    task automatic apb_access(input logic [1:0] index, input bit wr,
                              input logic [ipmd_pkg::APB_DATA_W-1:0] wdata,
                              output logic [ipmd_pkg::APB_DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ipmd_pkg::APB_ADDR_W'({index, 2'b00});
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [1:0] index);
        logic [ipmd_pkg::APB_DATA_W-1:0] got;
        apb_access(index, 1'b0, '0, got);
        if (got !== reg_mirror(index))
        begin
            $error("prdata reg %0d: expected %0h, actual %0h", index, reg_mirror(index), got);
            fault_count++;
        end
    endtask

    task automatic write_reg(input logic [1:0] index,
                             input logic [ipmd_pkg::APB_DATA_W-1:0] data);
        logic [ipmd_pkg::APB_DATA_W-1:0] unused;
        apb_access(index, 1'b1, data, unused);
        case (index)
            ipmd_pkg::REG_GAIN_P:    kp_cfg = data[ipmd_pkg::GAIN_W-1:0];
            ipmd_pkg::REG_GAIN_I:    ki_cfg = data[ipmd_pkg::GAIN_W-1:0];
            ipmd_pkg::REG_LV_THRESH: lv_cfg = data[ipmd_pkg::VOLT_W-1:0];
            default:                 ;
        endcase
        if (index != REG_SPARE)
        begin
            check_reg(index);
        end
    endtask

    task automatic send_tick(input ipmd_pkg::item_t it);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
        begin
            send_calm = !send_calm;
        end
        gap = send_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        expected_drive.push_back(predict_drive(it));
    endtask

    task automatic settle_block();
        item_valid <= 1'b0;
        while (expected_drive.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_beat(input ipmd_pkg::result_t got);
        ipmd_pkg::result_t want;
        if (expected_drive.size() == 0)
        begin
            $error("result beat with nothing expected: %p", got);
            fault_count++;
        end
        else
        begin
            want = expected_drive.pop_front();
            if (got.out_channel !== want.out_channel)
            begin
                $error("out_channel: expected %0d, actual %0d", want.out_channel, got.out_channel);
                fault_count++;
            end
            if (got.pwm_magnitude !== want.pwm_magnitude)
            begin
                $error("pwm_magnitude: expected %0d, actual %0d",
                       want.pwm_magnitude, got.pwm_magnitude);
                fault_count++;
            end
            if (got.pin_one !== want.pin_one)
            begin
                $error("pin_one: expected %0d, actual %0d", want.pin_one, got.pin_one);
                fault_count++;
            end
            if (got.pin_two !== want.pin_two)
            begin
                $error("pin_two: expected %0d, actual %0d", want.pin_two, got.pin_two);
                fault_count++;
            end
            if (got.drive_blocked !== want.drive_blocked)
            begin
                $error("drive_blocked: expected %0d, actual %0d",
                       want.drive_blocked, got.drive_blocked);
                fault_count++;
            end
        end
    endtask

    // result side: random stall before each beat
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                recv_calm = !recv_calm;
            end
            stall = recv_calm ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (result_valid !== 1'b1);
            check_beat(result);
        end
    end

    task automatic test_register_reset();
        check_reg(ipmd_pkg::REG_GAIN_P);
        check_reg(ipmd_pkg::REG_GAIN_I);
        check_reg(ipmd_pkg::REG_LV_THRESH);
    endtask

    task automatic test_blocked_drive();
        send_tick(make_tick(0, 0, 1000, 19, 1, 0));
        send_tick(make_tick(0, 0, 1000, 20, 1, 0));
        send_tick(make_tick(1, 0, -1000, 0, 1, 0));
        send_tick(make_tick(2, 0, 1000, 65535, 1, 0));
        send_tick(make_tick(3, 0, 1000, 500, 0, 0));
        send_tick(make_tick(3, 0, 1000, 500, 1, 1));
        settle_block();
    endtask

    task automatic test_saturation();
        write_reg(ipmd_pkg::REG_GAIN_P, 32'h00FF_FFFF);
        write_reg(ipmd_pkg::REG_GAIN_I, 32'hFFFF_FFFF);
        for (int ch = 0; ch < ipmd_pkg::MOTOR_COUNT; ch++)
        begin
            send_tick(make_tick(ipmd_pkg::CH_W'(ch), -32768, 32767, 1000, 1, 0));
            send_tick(make_tick(ipmd_pkg::CH_W'(ch), 32767, -32768, 1000, 1, 0));
        end
        send_tick(make_tick(0, 1234, 1234, 1000, 1, 0));
        // held state across a blocked tick
        send_tick(make_tick(1, -32768, 32767, 1000, 1, 1));
        send_tick(make_tick(1, 0, 1, 1000, 1, 0));
        settle_block();
    endtask

    task automatic test_threshold_extremes();
        write_reg(ipmd_pkg::REG_GAIN_P, 32'h0000_0100);
        write_reg(ipmd_pkg::REG_GAIN_I, 32'h0000_0001);
        write_reg(ipmd_pkg::REG_LV_THRESH, 32'hABCD_FFFF);
        send_tick(make_tick(2, -4096, 4096, 65535, 1, 0));
        send_tick(make_tick(2, -4096, 4096, 65534, 1, 0));
        settle_block();
        write_reg(ipmd_pkg::REG_LV_THRESH, 32'h0000_0000);
        send_tick(make_tick(3, 4096, -4096, 0, 1, 0));
        send_tick(make_tick(0, -40, 40, 0, 1, 0));
        settle_block();
    endtask

    task automatic test_spare_register();
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        check_reg(ipmd_pkg::REG_GAIN_P);
        check_reg(ipmd_pkg::REG_GAIN_I);
        check_reg(ipmd_pkg::REG_LV_THRESH);
        send_tick(make_tick(1, -300, 300, 100, 1, 0));
        settle_block();
    endtask

    task automatic test_random_ticks();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(ipmd_pkg::REG_GAIN_P, 32'h00FF_FFFF);
                    write_reg(ipmd_pkg::REG_GAIN_I, 32'h00FF_FFFF);
                    write_reg(ipmd_pkg::REG_LV_THRESH, 32'h0000_0000);
                end
                1:
                begin
                    write_reg(ipmd_pkg::REG_GAIN_P, 32'h0000_0000);
                    write_reg(ipmd_pkg::REG_GAIN_I, 32'h0000_0000);
                    write_reg(ipmd_pkg::REG_LV_THRESH, 32'h0000_FFFF);
                end
                default:
                begin
                    write_reg(ipmd_pkg::REG_GAIN_P,
                              {8'($urandom), 24'($urandom_range(0, 1 << 19))});
                    write_reg(ipmd_pkg::REG_GAIN_I,
                              {8'($urandom), 24'($urandom_range(0, 1 << 15))});
                    write_reg(ipmd_pkg::REG_LV_THRESH,
                              {16'($urandom), 16'($urandom_range(0, 4000))});
                end
            endcase
            repeat (250) send_tick(random_tick());
            settle_block();
        end
    endtask

    initial
    begin
        kp_cfg = '0;
        ki_cfg = '0;
        lv_cfg = ipmd_pkg::LV_THRESHOLD_RESET;
        for (int i = 0; i < ipmd_pkg::MOTOR_COUNT; i++)
        begin
            wheel_last_error[i] = '0;
            wheel_accum[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_reset();
        test_blocked_drive();
        test_saturation();
        test_threshold_extremes();
        test_spare_register();
        test_random_ticks();
        settle_block();
        repeat (8) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #3200000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== incremental_pi_motor_drive.f =====
hdl/ipmd_pkg.sv
hdl/incremental_pi_motor_drive.sv
hdl/ipmd_checker.sv
tb/incremental_pi_motor_drive_tb.sv
